// ----- hdl/bfbr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbr_pkg
// shared sizes, codes and helpers of the best-fit buffer reuse planner
// ----------------------------------------------------------------------------
package bfbr_pkg;

    localparam int NUM_BUFFERS = 64;
    localparam int NUM_TENSORS = 256;

    localparam int OP_W   = 1;
    localparam int TID_W  = 8;
    localparam int SIZE_W = 31;
    localparam int CL_W   = 8;
    localparam int ID_W   = 6;
    localparam int ST_W   = 2;
    localparam int TOT_W  = 40;

    localparam int BIDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W  = BIDX_W + 1;
    localparam int TIDX_W = (NUM_TENSORS > 1) ? $clog2(NUM_TENSORS) : 1;
    localparam int ENTRY_W = SIZE_W + CL_W;

    localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE    = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_UNMAPPED = 2'd2;

    // control of the shared fit unit
    typedef struct packed {
        logic clear;
        logic step;
    } t_fit_ctl;

    // running best candidate
    typedef struct packed {
        logic              found;
        logic [BIDX_W-1:0] best;
    } t_fit_res;

    // tensor id reduced modulo the tensor table depth, a power of two
    function automatic logic [TIDX_W-1:0] tensor_index(input logic [TID_W-1:0] id);
        logic [31:0] w;
        w = 32'(id) & (32'(NUM_TENSORS) - 32'd1);
        return w[TIDX_W-1:0];
    endfunction

    // low bits of a slot number as reported on the result
    function automatic logic [ID_W-1:0] buf_id(input logic [BIDX_W-1:0] b);
        logic [BIDX_W+ID_W-1:0] w;
        w = {{ID_W{1'b0}}, b};
        return w[ID_W-1:0];
    endfunction

    // saturating running total
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] acc,
                                                 input logic [SIZE_W-1:0] inc);
        logic [TOT_W:0] s;
        s = {1'b0, acc} + (TOT_W + 1)'(inc);
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

// ----- hdl/best_fit_buffer_reuse_core.sv -----
// ----------------------------------------------------------------------------
// best_fit_buffer_reuse_core
// best-fit buffer reuse planner: picks the tightest free buffer of a cluster,
// opens fresh slots, maps tensors to buffers and frees them again
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  --------------------------------
//  request   in         i_in_valid / o_in_ready   operation, tensor_id, size_bytes,
//                                                 cluster_id
//  result    out        o_out_valid / i_out_ready buffer_id, new_buffer, status,
//                                                 allocated_bytes, saved_bytes
//
//  a request beat runs through an accept step, a scan of every opened slot through
//  the buffer table read port at one slot per cycle, a drain step for the last
//  compare and an update step; while no slot is open yet it skips the scan and
//  drain. a free beat runs through accept, a tensor table read and the free step.
//  reset clears the state machine, slot count, totals and the free/mapped flags;
//  sizes, clusters and mappings are written before use.
//  a finished result waits in the output register while the next beat is
//  accepted; the update and free steps hold while that register is still full.
//
module best_fit_buffer_reuse_core
    import bfbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [TID_W-1:0]  i_tensor_id,
    input  logic [SIZE_W-1:0] i_size_bytes,
    input  logic [CL_W-1:0]   i_cluster_id,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ID_W-1:0]   o_buffer_id,
    output logic              o_new_buffer,
    output logic [ST_W-1:0]   o_status,
    output logic [TOT_W-1:0]  o_allocated_bytes,
    output logic [TOT_W-1:0]  o_saved_bytes
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_TREAD  = 6'b010000,
        S_FREE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // latched request beat
    logic [TIDX_W-1:0] r_tidx;
    logic [SIZE_W-1:0] r_size;
    logic [CL_W-1:0]   r_cl;

    // slot table bookkeeping
    logic [CNT_W-1:0]       r_count;
    logic [NUM_BUFFERS-1:0] r_free;
    logic [NUM_TENSORS-1:0] r_mapped;
    logic [TOT_W-1:0]       r_total_alloc;
    logic [TOT_W-1:0]       r_total_saved;

    // scan address and compare stage tag
    logic [BIDX_W-1:0] r_idx;
    logic [BIDX_W-1:0] r_cmp_idx;
    logic              r_cmp_vld;

    // result register
    logic              r_out_valid;
    logic [ID_W-1:0]   r_buffer_id;
    logic              r_new_buffer;
    logic [ST_W-1:0]   r_status;
    logic [TOT_W-1:0]  r_out_alloc;
    logic [TOT_W-1:0]  r_out_saved;

    logic              in_accept;
    logic              out_free;
    logic              scan_last;
    logic              has_room;
    logic              do_update;
    logic              do_free;
    logic              open_slot;

    logic [ENTRY_W-1:0] bram_rdata;
    logic [ENTRY_W-1:0] bram_wdata;
    logic [BIDX_W-1:0]  tram_rdata;
    logic [BIDX_W-1:0]  tram_wdata;
    logic               tram_we;

    t_fit_ctl fit_ctl;
    t_fit_res fit_res;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_last = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
    assign has_room  = (r_count < CNT_W'(NUM_BUFFERS));
    assign do_update = (r_state == S_UPDATE) && out_free;
    assign do_free   = (r_state == S_FREE) && out_free;
    assign open_slot = do_update && !fit_res.found && has_room;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_operation == OP_FREE) begin
                        n_state = S_TREAD;
                    end else if (r_count == '0) begin
                        n_state = S_UPDATE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_UPDATE;
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TREAD:  n_state = S_FREE;
            S_FREE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
        end
    end

    // latch the beat and walk the scan address
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tidx <= tensor_index(i_tensor_id);
            r_size <= i_size_bytes;
            r_cl   <= i_cluster_id;
            r_idx  <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + BIDX_W'(1);
        end
        r_cmp_idx <= r_idx;
    end

    // ---- tables: sizes/clusters and tensor mappings ----
    assign bram_wdata = {r_size, r_cl};

    bfbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUFFERS)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (open_slot),
        .i_waddr (r_count[BIDX_W-1:0]),
        .i_wdata (bram_wdata),
        .i_raddr (r_idx),
        .o_rdata (bram_rdata)
    );

    assign tram_we    = do_update && (fit_res.found || has_room);
    assign tram_wdata = fit_res.found ? fit_res.best : r_count[BIDX_W-1:0];

    bfbr_ram #(
        .WIDTH (BIDX_W),
        .DEPTH (NUM_TENSORS)
    ) u_tensor_ram (
        .i_clk   (i_clk),
        .i_we    (tram_we),
        .i_waddr (r_tidx),
        .i_wdata (tram_wdata),
        .i_raddr (r_tidx),
        .o_rdata (tram_rdata)
    );

    // ---- shared compare unit, one slot per cycle ----
    assign fit_ctl.clear = in_accept;
    assign fit_ctl.step  = r_cmp_vld;

    bfbr_fit_unit u_fit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (fit_ctl),
        .i_idx           (r_cmp_idx),
        .i_entry_size    (bram_rdata[ENTRY_W-1:CL_W]),
        .i_entry_cluster (bram_rdata[CL_W-1:0]),
        .i_entry_free    (r_free[r_cmp_idx]),
        .i_req_size      (r_size),
        .i_req_cluster   (r_cl),
        .o_res           (fit_res)
    );

    // ---- state updates: flags, count and totals ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_free        <= '0;
            r_mapped      <= '0;
            r_total_alloc <= '0;
            r_total_saved <= '0;
        end else begin
            if (do_update && fit_res.found) begin
                // reuse hit: buffer goes busy
                r_free[fit_res.best] <= 1'b0;
                r_mapped[r_tidx]     <= 1'b1;
                r_total_saved        <= sat_add(r_total_saved, r_size);
            end else if (open_slot) begin
                // fresh slot is busy from the start, its free flag is still clear
                r_count          <= r_count + CNT_W'(1);
                r_mapped[r_tidx] <= 1'b1;
                r_total_alloc    <= sat_add(r_total_alloc, r_size);
            end
            if (do_free && r_mapped[r_tidx]) begin
                r_free[tram_rdata] <= 1'b1;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_update || do_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            if (fit_res.found) begin
                r_buffer_id  <= buf_id(fit_res.best);
                r_new_buffer <= 1'b0;
                r_status     <= ST_OK;
                r_out_alloc  <= r_total_alloc;
                r_out_saved  <= sat_add(r_total_saved, r_size);
            end else if (has_room) begin
                r_buffer_id  <= buf_id(r_count[BIDX_W-1:0]);
                r_new_buffer <= 1'b1;
                r_status     <= ST_OK;
                r_out_alloc  <= sat_add(r_total_alloc, r_size);
                r_out_saved  <= r_total_saved;
            end else begin
                // table full, nothing changes
                r_buffer_id  <= '0;
                r_new_buffer <= 1'b0;
                r_status     <= ST_FULL;
                r_out_alloc  <= r_total_alloc;
                r_out_saved  <= r_total_saved;
            end
        end else if (do_free) begin
            r_out_alloc  <= r_total_alloc;
            r_out_saved  <= r_total_saved;
            r_new_buffer <= 1'b0;
            if (r_mapped[r_tidx]) begin
                r_buffer_id <= buf_id(tram_rdata);
                r_status    <= ST_OK;
            end else begin
                r_buffer_id <= '0;
                r_status    <= ST_UNMAPPED;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_buffer_id       = r_buffer_id;
    assign o_new_buffer      = r_new_buffer;
    assign o_status          = r_status;
    assign o_allocated_bytes = r_out_alloc;
    assign o_saved_bytes     = r_out_saved;

endmodule

// ----- hdl/bfbr_ram.sv -----
// ----------------------------------------------------------------------------
// bfbr_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module bfbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bfbr_fit_unit.sv -----
// ----------------------------------------------------------------------------
// bfbr_fit_unit
// shared subtract and compare unit that keeps the tightest fitting buffer
// ----------------------------------------------------------------------------
module bfbr_fit_unit
    import bfbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fit_ctl          i_ctl,
    input  logic [BIDX_W-1:0] i_idx,
    input  logic [SIZE_W-1:0] i_entry_size,
    input  logic [CL_W-1:0]   i_entry_cluster,
    input  logic              i_entry_free,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [CL_W-1:0]   i_req_cluster,
    output t_fit_res          o_res
);

    logic              r_found;
    logic [BIDX_W-1:0] r_best;
    logic [SIZE_W-1:0] r_best_diff;

    logic              eligible;
    logic [SIZE_W-1:0] diff;
    logic              take;

    assign eligible = i_entry_free && (i_entry_cluster == i_req_cluster)
                      && (i_entry_size >= i_req_size);
    assign diff     = i_entry_size - i_req_size;
    // strict less keeps the lowest index on ties
    assign take     = eligible && (!r_found || (diff < r_best_diff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.step && take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && take && !i_ctl.clear) begin
            r_best      <= i_idx;
            r_best_diff <= diff;
        end
    end

    assign o_res.found = r_found;
    assign o_res.best  = r_best;

endmodule
